@@ rtl/tfm_pkg.sv @@
// Package for the topic filter match core: sizes, character codes,
// request kinds and the command word passed from front end to back end.
// No dependencies.
package tfm_pkg;

  localparam int MAX_FILTER_LEN = 64;
  localparam int AW = $clog2(MAX_FILTER_LEN);       // filter RAM index
  localparam int LW = $clog2(MAX_FILTER_LEN + 1);   // filter length / walk position
  localparam int TW = $clog2(MAX_FILTER_LEN + 2);   // saturating topic count

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TOPIC  = 2'd2,
    REQ_END    = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t  kind;
    logic [7:0] ch;
  } cmd_t;

endpackage

@@ rtl/tfm_req_if.sv @@
// Request channel: valid/ready handshake carrying req_type and char_code.
// No dependencies.
interface tfm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

@@ rtl/tfm_res_if.sv @@
// Result channel: valid/ready handshake carrying match and filter_overflow.
// No dependencies.
interface tfm_res_if;
  logic valid;
  logic ready;
  logic match;
  logic filter_overflow;

  modport source (output valid, output match, output filter_overflow, input ready);
  modport sink   (input valid, input match, input filter_overflow, output ready);
endinterface

@@ rtl/topic_filter_match_core.sv @@
// Matches a streamed topic against a stored wildcard filter ('+' one level,
// '#' the rest). Request words go into a two-word queue; the back end runs
// them one at a time. Clear and append finish in the idle state; a topic byte
// issues its registered filter RAM reads there and is checked in the topic
// state, with a walk state for each further read when '+' meets a '/'. An end
// of topic goes to the end state, which registers the result word once the
// result channel is free. Filter holds 64 bytes; extra appends are dropped and
// flagged. Depends on tfm_pkg, tfm_req_if, tfm_res_if, tfm_front and tfm_back.
module topic_filter_match_core (
  input  logic      clk,
  input  logic      rst,
  tfm_req_if.sink   req_ch,
  tfm_res_if.source res_ch
);
  import tfm_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  tfm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_ch    (req_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  tfm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_ch    (res_ch)
  );

endmodule

@@ rtl/tfm_front.sv @@
// Front end: accepts request words, decodes the request kind and queues
// commands for the back end. Depends on tfm_pkg and tfm_req_if.
module tfm_front (
  input  logic          clk,
  input  logic          rst,
  tfm_req_if.sink       req_ch,
  output tfm_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import tfm_pkg::*;

  cmd_t           q [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;
  cmd_t           in_cmd;

  assign in_cmd.kind  = req_kind_t'(req_ch.req_type);
  assign in_cmd.ch    = req_ch.char_code;
  assign req_ch.ready = (count < QCW'(QDEPTH));
  assign push         = req_ch.valid && req_ch.ready;
  assign cmd_valid    = (count != '0);
  assign pop          = cmd_valid && cmd_ready;
  assign cmd          = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/tfm_back.sv @@
// Back end: filter RAM, wildcard walk engine, exact-equality tracking and
// the result register. Depends on tfm_pkg and tfm_res_if.
module tfm_back (
  input  logic          clk,
  input  logic          rst,
  input  tfm_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  tfm_res_if.source     res_ch
);
  import tfm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TOPIC = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_END   = 4'b1000
  } state_t;

  logic [7:0]    mem [MAX_FILTER_LEN];
  logic [7:0]    rd_a;
  logic [7:0]    rd_b;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic          mem_we;

  state_t        state, state_next;
  logic [LW-1:0] filter_length, filter_length_next;
  logic [LW-1:0] filter_pos, filter_pos_next;
  logic [LW-1:0] pos_prev;
  logic [TW-1:0] topic_count, topic_count_next;
  logic          skipping, skipping_next;
  logic          verdict_known, verdict_known_next;
  logic          verdict_value, verdict_value_next;
  logic          exact_ok, exact_ok_next;
  logic          overflowed, overflowed_next;
  logic [7:0]    cur_char;
  logic          res_valid;
  logic          res_match;
  logic          res_ovf;
  logic          res_load;
  logic          end_match;
  logic          topic_pop;

  assign cmd_ready = (state == ST_IDLE);
  assign topic_pop = cmd_valid && (state == ST_IDLE) && (cmd.kind == REQ_TOPIC);
  assign pos_prev  = filter_pos_next - LW'(1);
  assign addr_a    = topic_pop ? topic_count[AW-1:0] : pos_prev[AW-1:0];
  assign addr_b    = filter_pos_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[filter_length[AW-1:0]] <= cmd.ch;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_comb begin
    end_match = 1'b0;
    if (exact_ok && (topic_count == TW'(filter_length))) begin
      end_match = 1'b1;
    end else if (verdict_known) begin
      end_match = verdict_value;
    end else if ((filter_pos < filter_length) && (rd_b == CH_HASH) &&
                 ((filter_pos == '0) || (rd_a == CH_SLASH))) begin
      end_match = 1'b1;
    end else begin
      end_match = (filter_pos >= filter_length);
    end
  end

  always_comb begin
    state_next         = state;
    filter_length_next = filter_length;
    filter_pos_next    = filter_pos;
    topic_count_next   = topic_count;
    skipping_next      = skipping;
    verdict_known_next = verdict_known;
    verdict_value_next = verdict_value;
    exact_ok_next      = exact_ok;
    overflowed_next    = overflowed;
    mem_we             = 1'b0;
    res_load           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            REQ_CLEAR: begin
              filter_length_next = '0;
              overflowed_next    = 1'b0;
              filter_pos_next    = '0;
              skipping_next      = 1'b0;
              verdict_known_next = 1'b0;
              verdict_value_next = 1'b0;
              exact_ok_next      = 1'b1;
              topic_count_next   = '0;
            end
            REQ_APPEND: begin
              if (filter_length < LW'(MAX_FILTER_LEN)) begin
                mem_we             = 1'b1;
                filter_length_next = filter_length + LW'(1);
              end else begin
                overflowed_next = 1'b1;
              end
            end
            REQ_TOPIC: state_next = ST_TOPIC;
            default:   state_next = ST_END;
          endcase
        end
      end
      ST_TOPIC, ST_WALK: begin
        if (state == ST_TOPIC) begin
          if (topic_count < TW'(filter_length)) begin
            if (rd_a != cur_char) begin
              exact_ok_next = 1'b0;
            end
            topic_count_next = topic_count + TW'(1);
          end else begin
            exact_ok_next = 1'b0;
            if (topic_count <= TW'(MAX_FILTER_LEN)) begin
              topic_count_next = topic_count + TW'(1);
            end
          end
        end
        state_next = ST_IDLE;
        if (!verdict_known && !(skipping && (cur_char != CH_SLASH))) begin
          skipping_next = 1'b0;
          if (filter_pos >= filter_length) begin
            verdict_known_next = 1'b1;
            verdict_value_next = 1'b0;
          end else if (rd_b == CH_PLUS) begin
            filter_pos_next = filter_pos + LW'(1);
            if (cur_char != CH_SLASH) begin
              skipping_next = 1'b1;
            end else begin
              state_next = ST_WALK;
            end
          end else if (rd_b == CH_HASH) begin
            verdict_known_next = 1'b1;
            verdict_value_next = 1'b1;
          end else if (rd_b == cur_char) begin
            filter_pos_next = filter_pos + LW'(1);
          end else begin
            verdict_known_next = 1'b1;
            verdict_value_next = 1'b0;
          end
        end
      end
      ST_END: begin
        if (!res_valid || res_ch.ready) begin
          res_load           = 1'b1;
          filter_pos_next    = '0;
          skipping_next      = 1'b0;
          verdict_known_next = 1'b0;
          verdict_value_next = 1'b0;
          exact_ok_next      = 1'b1;
          topic_count_next   = '0;
          state_next         = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      filter_length <= '0;
      filter_pos    <= '0;
      topic_count   <= '0;
      skipping      <= 1'b0;
      verdict_known <= 1'b0;
      verdict_value <= 1'b0;
      exact_ok      <= 1'b1;
      overflowed    <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      filter_length <= filter_length_next;
      filter_pos    <= filter_pos_next;
      topic_count   <= topic_count_next;
      skipping      <= skipping_next;
      verdict_known <= verdict_known_next;
      verdict_value <= verdict_value_next;
      exact_ok      <= exact_ok_next;
      overflowed    <= overflowed_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (topic_pop) begin
      cur_char <= cmd.ch;
    end
    if (res_load) begin
      res_match <= end_match;
      res_ovf   <= overflowed;
    end
  end

  assign res_ch.valid           = res_valid;
  assign res_ch.match           = res_match;
  assign res_ch.filter_overflow = res_ovf;

  a_pos_in_filter: assert property (@(posedge clk) disable iff (rst)
    filter_pos <= filter_length)
    else $error("walk position beyond filter length");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    topic_count <= TW'(MAX_FILTER_LEN + 1))
    else $error("topic count past saturation");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> (filter_length == LW'(MAX_FILTER_LEN)))
    else $error("overflow flagged with filter not full");

  a_walk_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> ($past(state) == ST_TOPIC || $past(state) == ST_WALK))
    else $error("walk continuation without a topic word");

endmodule

@@ sim/topic_filter_match_core_tb.sv @@
// Testbench for topic_filter_match_core: streams filter and topic words and checks
// every verdict word against a predictor of the wildcard walk.
// Depends on tfm_pkg, tfm_req_if, tfm_res_if and the core RTL.
module topic_filter_match_core_tb;
  import tfm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int WORD_TARGET = 850;
  localparam int CALM_TAIL   = 150;

  typedef struct packed {
    logic match;
    logic overflow;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfm_req_if req_ch ();
  tfm_res_if res_ch ();

  topic_filter_match_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .res_ch (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [7:0] flt_bytes [MAX_FILTER_LEN];
  int         flt_len;
  int         walk_pos;
  int         topic_len;
  bit         in_plus_skip;
  bit         walk_decided;
  bit         walk_result;
  bit         flt_dropped;
  bit         same_so_far;

  verdict_t   expected_verdicts [$];
  int         error_count;
  int         words_sent;
  int         idle_cycles;
  bit         idle_on;
  bit         drain_each;
  int         ready_hold;

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  function automatic void restart_walk();
    walk_pos     = 0;
    in_plus_skip = 1'b0;
    walk_decided = 1'b0;
    walk_result  = 1'b0;
    same_so_far  = 1'b1;
    topic_len    = 0;
  endfunction

  function automatic void walk_topic_byte(logic [7:0] c);
    logic [7:0] fc;
    bit         done;
    if (topic_len < flt_len) begin
      if (flt_bytes[topic_len] != c) same_so_far = 1'b0;
      topic_len++;
    end else begin
      same_so_far = 1'b0;
      if (topic_len <= MAX_FILTER_LEN) topic_len++;
    end
    if (walk_decided) return;
    if (in_plus_skip) begin
      if (c != CH_SLASH) return;
      in_plus_skip = 1'b0;
    end
    done = 1'b0;
    while (!done) begin
      if (walk_pos >= flt_len) begin
        walk_decided = 1'b1;
        walk_result  = 1'b0;
        done         = 1'b1;
      end else begin
        fc = flt_bytes[walk_pos];
        if (fc == CH_PLUS) begin
          walk_pos++;
          if (c != CH_SLASH) begin
            in_plus_skip = 1'b1;
            done         = 1'b1;
          end
        end else if (fc == CH_HASH) begin
          walk_decided = 1'b1;
          walk_result  = 1'b1;
          done         = 1'b1;
        end else if (fc == c) begin
          walk_pos++;
          done = 1'b1;
        end else begin
          walk_decided = 1'b1;
          walk_result  = 1'b0;
          done         = 1'b1;
        end
      end
    end
  endfunction

  function automatic logic topic_verdict();
    if (same_so_far && topic_len == flt_len) return 1'b1;
    if (walk_decided) return walk_result;
    if (walk_pos < flt_len && flt_bytes[walk_pos] == CH_HASH &&
        (walk_pos == 0 || flt_bytes[walk_pos - 1] == CH_SLASH)) return 1'b1;
    return walk_pos >= flt_len;
  endfunction

  function automatic void predict_word(req_kind_t kind, logic [7:0] ch);
    verdict_t v;
    case (kind)
      REQ_CLEAR: begin
        flt_len     = 0;
        flt_dropped = 1'b0;
        restart_walk();
      end
      REQ_APPEND: begin
        if (flt_len < MAX_FILTER_LEN) begin
          flt_bytes[flt_len] = ch;
          flt_len++;
        end else begin
          flt_dropped = 1'b1;
        end
      end
      REQ_TOPIC: walk_topic_byte(ch);
      default: begin
        v.match    = topic_verdict();
        v.overflow = flt_dropped;
        expected_verdicts = {expected_verdicts, v};
        restart_walk();
      end
    endcase
  endfunction

  task automatic send_word(req_kind_t kind, logic [7:0] ch);
    if (drain_each) begin
      if (expected_verdicts.size() != 0) begin
        req_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
      end
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.char_code <= ch;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_word(kind, ch);
    words_sent++;
  endtask

  task automatic load_filter(string s);
    send_word(REQ_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < s.len(); i++) send_word(REQ_APPEND, s[i]);
  endtask

  task automatic send_topic_end(string s);
    for (int i = 0; i < s.len(); i++) send_word(REQ_TOPIC, s[i]);
    send_word(REQ_END, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_level_byte();
    case ($urandom_range(0, 3))
      0:       return "a";
      1:       return "b";
      2:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_filter_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return "a";
    if (r < 40) return "b";
    if (r < 65) return CH_SLASH;
    if (r < 80) return CH_PLUS;
    if (r < 90) return CH_HASH;
    return 8'($urandom_range(0, 255));
  endfunction

  // one filter load followed by a few topics, mostly shaped to fit the filter
  task automatic run_session();
    logic [7:0] fq [$];
    logic [7:0] tq [$];
    int         flen;
    int         ntopics;
    int         k;
    if ($urandom_range(0, 7) != 0) send_word(REQ_CLEAR, 8'($urandom_range(0, 255)));
    flen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 8);
    fq.delete();
    repeat (flen) fq = {fq, pick_filter_byte()};
    foreach (fq[i]) send_word(REQ_APPEND, fq[i]);
    ntopics = $urandom_range(1, 3);
    repeat (ntopics) begin
      tq.delete();
      if ($urandom_range(0, 9) < 6) begin
        foreach (fq[i]) begin
          if (fq[i] == CH_PLUS) begin
            repeat ($urandom_range(0, 3)) tq = {tq, pick_level_byte()};
          end else if (fq[i] == CH_HASH) begin
            repeat ($urandom_range(0, 4))
              tq = {tq, ($urandom_range(0, 2) == 0) ? CH_SLASH : pick_level_byte()};
            break;
          end else begin
            tq = {tq, fq[i]};
          end
        end
        if (tq.size() > 0 && $urandom_range(0, 4) == 0)
          tq[$urandom_range(0, tq.size() - 1)] = pick_filter_byte();
        k = $urandom_range(0, 9);
        if (k == 0) tq = {tq, CH_SLASH};
        else if (k == 1 && tq.size() > 0) void'(tq.pop_back());
      end else begin
        repeat ($urandom_range(0, 8)) tq = {tq, pick_filter_byte()};
      end
      foreach (tq[i]) begin
        if ($urandom_range(0, 29) == 0)
          send_word(req_kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        send_word(REQ_TOPIC, tq[i]);
      end
      send_word(REQ_END, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_empty_after_reset();
    send_word(REQ_END, 8'hFF);
  endtask

  task automatic test_hash_filters();
    load_filter("#");
    send_topic_end("");
    send_topic_end("x");
    load_filter("a/#");
    send_topic_end("a");
  endtask

  task automatic test_plus_and_byte_extremes();
    send_word(REQ_CLEAR, 8'h00);
    send_word(REQ_APPEND, CH_PLUS);
    send_word(REQ_APPEND, CH_SLASH);
    send_word(REQ_APPEND, 8'h00);
    send_word(REQ_TOPIC, "q");
    send_word(REQ_TOPIC, CH_SLASH);
    send_word(REQ_TOPIC, 8'h00);
    send_word(REQ_END, 8'h00);
    send_word(REQ_TOPIC, 8'hFF);
    send_word(REQ_END, 8'hFF);
  endtask

  task automatic test_midtopic_changes();
    send_word(REQ_TOPIC, "q");
    send_word(REQ_APPEND, CH_HASH);
    send_word(REQ_TOPIC, CH_SLASH);
    send_word(REQ_END, 8'h00);
    send_word(REQ_TOPIC, "a");
    send_word(REQ_CLEAR, 8'hFF);
    send_word(REQ_END, 8'h00);
  endtask

  task automatic test_filter_full();
    logic [7:0] fq [$];
    send_word(REQ_CLEAR, 8'h00);
    repeat (MAX_FILTER_LEN + 1) fq = {fq, 8'($urandom_range(0, 255))};
    foreach (fq[i]) send_word(REQ_APPEND, fq[i]);
    for (int i = 0; i < MAX_FILTER_LEN; i++) send_word(REQ_TOPIC, fq[i]);
    send_word(REQ_END, 8'h00);
    for (int i = 0; i < MAX_FILTER_LEN + 2; i++) send_word(REQ_TOPIC, "a");
    send_word(REQ_END, 8'h00);
    send_word(REQ_CLEAR, 8'h00);
    send_word(REQ_END, 8'h00);
  endtask

  task automatic test_drained_sender();
    drain_each = 1'b1;
    repeat (2) run_session();
    drain_each = 1'b0;
  endtask

  task automatic test_random_sessions();
    while (words_sent < WORD_TARGET) begin
      idle_on = (words_sent < WORD_TARGET - CALM_TAIL);
      run_session();
    end
  endtask

  // result sink: ready in random stall bursts
  initial begin
    res_ch.ready = 1'b0;
    ready_hold   = 0;
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        ready_hold = $urandom_range(1, 10);
      end
      res_ch.ready <= (ready_hold == 0);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result word match=%b overflow=%b",
                                  res_ch.match, res_ch.filter_overflow));
      end else begin
        want = expected_verdicts.pop_front();
        if (res_ch.match !== want.match)
          report_mismatch($sformatf("match got %b want %b", res_ch.match, want.match));
        if (res_ch.filter_overflow !== want.overflow)
          report_mismatch($sformatf("filter_overflow got %b want %b",
                                    res_ch.filter_overflow, want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_CLEAR;
    req_ch.char_code = 8'h00;
    idle_cycles      = 0;
    error_count      = 0;
    words_sent       = 0;
    idle_on          = 1'b1;
    drain_each       = 1'b0;
    flt_len          = 0;
    flt_dropped      = 1'b0;
    restart_walk();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_after_reset();
    test_hash_filters();
    test_plus_and_byte_extremes();
    test_midtopic_changes();
    test_filter_full();
    test_drained_sender();
    test_random_sessions();

    req_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ topic_filter_match_core.f @@
rtl/tfm_pkg.sv
rtl/tfm_req_if.sv
rtl/tfm_res_if.sv
rtl/tfm_front.sv
rtl/tfm_back.sv
rtl/topic_filter_match_core.sv
sim/topic_filter_match_core_tb.sv
